// ===== hw/rtl/pcbr_pkg.sv =====
// pcbr_pkg: shared types and constants for the position counter with bcd readout
// no dependencies; imported by the channel interfaces and the top level

package pcbr_pkg;

	localparam int PADDR_W = 3;
	localparam int REG_IDX_BIT = 2;

	// register index of step_size
	localparam logic REG_STEP = 1'b0;

	localparam logic [3:0] STEP_RESET = 4'd2;
	localparam logic signed [16:0] COUNT_MAX = 17'sd32766;
	localparam logic signed [16:0] COUNT_MIN = -17'sd32766;

	localparam logic [7:0] ASCII_ZERO  = 8'h30;
	localparam logic [7:0] ASCII_POINT = 8'h2E;
	localparam logic [7:0] ASCII_MINUS = 8'h2D;
	localparam logic [7:0] ASCII_PLUS  = 8'h2B;

	// place of a character within a report
	typedef enum logic [2:0] {
		CH_SIGN  = 3'd0,
		CH_THOU  = 3'd1,
		CH_HUND  = 3'd2,
		CH_POINT = 3'd3,
		CH_TENS  = 3'd4,
		CH_UNITS = 3'd5
	} char_idx_t;

	typedef struct packed {
		logic req_type;
		logic moving_left;
	} item_t;

	typedef struct packed {
		logic [7:0] char_code;
		logic       last_char;
	} result_t;

endpackage

// ===== hw/rtl/pcbr_if.sv =====
// pcbr_if: valid/ready channel interfaces for input items and result characters
// depends on pcbr_pkg for the payload types

interface pcbr_item_if;
	import pcbr_pkg::*;
	logic  valid;
	logic  ready;
	item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface pcbr_result_if;
	import pcbr_pkg::*;
	logic    valid;
	logic    ready;
	result_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== hw/rtl/position_count_bcd_readout.sv =====
// position_count_bcd_readout: saturating position counter with six-character bcd readout
// an edge request updates the count the cycle after acceptance; a report passes stage 1,
// both conversion stages and readout registers, then one character per taken cycle
// one request per cycle unless a report stalls in stage 1; a report holds the result port for six characters
// reset: arst_n clears the count to zero, sets step_size to 2 and empties all stages
// depends on pcbr_pkg and pcbr_if

module position_count_bcd_readout (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [pcbr_pkg::PADDR_W-1:0] paddr,
	input  logic [31:0]                  pwdata,
	output logic [31:0]                  prdata,
	output logic                         pready,
	pcbr_item_if.sink                    item,
	pcbr_result_if.source                result
);
	import pcbr_pkg::*;

	// eight steps of shift-and-add-3 on a 16-bit bcd word
	function automatic logic [31:0] dabble8(input logic [15:0] bcd_in, input logic [15:0] bin_in);
		logic [15:0] bcd;
		logic [15:0] bin;
		bcd = bcd_in;
		bin = bin_in;
		for (int i = 0; i < 8; i++) begin
			for (int d = 0; d < 4; d++) begin
				if (bcd[4*d +: 4] >= 4'd5) bcd = bcd + (16'd3 << (4*d));
			end
			bcd = {bcd[14:0], bin[15]};
			bin = {bin[14:0], 1'b0};
		end
		return {bcd, bin};
	endfunction

	// configuration
	logic [3:0] step_q;
	logic       cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= STEP_RESET;
		end else if (cfg_wr && paddr[REG_IDX_BIT] == REG_STEP) begin
			step_q <= pwdata[3:0];
		end
	end

	always_comb begin
		prdata = 32'd0;
		if (paddr[REG_IDX_BIT] == REG_STEP) prdata = {28'd0, step_q};
	end

	// pipeline registers
	logic               v_s1;
	item_t              item_s1;
	logic               v_s2;
	logic               neg_s2;
	logic [15:0]        mag_s2;
	logic               v_s3;
	logic               neg_s3;
	logic [15:0]        bcd_s3;
	logic [15:0]        bin_s3;
	logic signed [15:0] count_q;

	// readout registers
	logic               busy_q;
	char_idx_t          idx_q;
	logic               neg_q;
	logic [15:0]        bcd_q;

	logic               last_taken;
	logic               load_drain;
	logic               en3;
	logic               en2;
	logic               adv1;
	logic [31:0]        dd_s2;
	logic [31:0]        dd_s3;
	logic signed [16:0] step_ext;
	logic signed [16:0] sum;
	logic signed [16:0] next_count;
	logic [15:0]        mag;

	assign last_taken = busy_q && result.ready && (idx_q == CH_UNITS);
	assign load_drain = v_s3 && (!busy_q || last_taken);
	assign en3 = !v_s3 || load_drain;
	assign en2 = !v_s2 || en3;
	// an edge request never waits; a report waits for room in the conversion stages
	assign adv1 = v_s1 && (!item_s1.req_type || en2);
	assign item.ready = !v_s1 || adv1;

	assign step_ext = signed'({13'd0, step_q});
	assign sum = item_s1.moving_left ? ({count_q[15], count_q} - step_ext)
	                                 : ({count_q[15], count_q} + step_ext);
	always_comb begin
		next_count = sum;
		if (sum > COUNT_MAX) next_count = COUNT_MAX;
		if (sum < COUNT_MIN) next_count = COUNT_MIN;
	end

	assign mag = count_q[15] ? (16'd0 - count_q) : count_q;
	assign dd_s2 = dabble8(16'd0, mag_s2);
	assign dd_s3 = dabble8(bcd_s3, bin_s3);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			v_s3    <= 1'b0;
			count_q <= '0;
			busy_q  <= 1'b0;
			idx_q   <= CH_SIGN;
		end else begin
			if (item.ready) v_s1 <= item.valid;
			if (adv1 && !item_s1.req_type) count_q <= next_count[15:0];
			if (en2) v_s2 <= adv1 && item_s1.req_type;
			if (en3) v_s3 <= v_s2;
			if (load_drain) begin
				busy_q <= 1'b1;
				idx_q  <= CH_SIGN;
			end else if (last_taken) begin
				busy_q <= 1'b0;
			end else if (busy_q && result.ready) begin
				idx_q <= char_idx_t'(idx_q + 3'd1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (item.ready) item_s1 <= item.data;
		if (en2) begin
			neg_s2 <= count_q[15];
			mag_s2 <= mag;
		end
		if (en3) begin
			neg_s3 <= neg_s2;
			bcd_s3 <= dd_s2[31:16];
			bin_s3 <= dd_s2[15:0];
		end
		if (load_drain) begin
			neg_q <= neg_s3;
			bcd_q <= dd_s3[31:16];
		end
	end

	// character select
	assign result.valid = busy_q;
	always_comb begin
		result.data.last_char = (idx_q == CH_UNITS);
		case (idx_q)
			CH_SIGN:  result.data.char_code = neg_q ? ASCII_MINUS : ASCII_PLUS;
			CH_THOU:  result.data.char_code = ASCII_ZERO + {4'd0, bcd_q[15:12]};
			CH_HUND:  result.data.char_code = ASCII_ZERO + {4'd0, bcd_q[11:8]};
			CH_POINT: result.data.char_code = ASCII_POINT;
			CH_TENS:  result.data.char_code = ASCII_ZERO + {4'd0, bcd_q[7:4]};
			CH_UNITS: result.data.char_code = ASCII_ZERO + {4'd0, bcd_q[3:0]};
			default:  result.data.char_code = ASCII_POINT;
		endcase
	end

endmodule

// ===== verif/pcbr_tb_pkg.sv =====
// pcbr_tb_pkg: request codes shared by the checker and the testbench top
// depends on nothing; compiled after pcbr_pkg and pcbr_if

package pcbr_tb_pkg;

	localparam logic REQ_EDGE   = 1'b0;
	localparam logic REQ_REPORT = 1'b1;

	localparam logic DIR_RIGHT = 1'b0;
	localparam logic DIR_LEFT  = 1'b1;

endpackage

// ===== verif/pcbr_checker.sv =====
// pcbr_checker: tracks the position count and step size, predicts each readout character
// and compares it with the result channel; also checks register reads
// depends on pcbr_pkg, pcbr_tb_pkg and the channel interfaces in pcbr_if

module pcbr_checker (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [pcbr_pkg::PADDR_W-1:0] paddr,
	input  logic [31:0]                  pwdata,
	input  logic [31:0]                  prdata,
	input  logic                         pready,
	pcbr_item_if                         item,
	pcbr_result_if                       result,
	output int                           fail_count,
	output int                           chars_pending
);
	import pcbr_pkg::*;
	import pcbr_tb_pkg::*;

	logic signed [15:0] position;
	logic [3:0]         step;
	result_t            readout_q[$];
	int                 errors;

	function automatic logic signed [15:0] moved_position(input logic signed [15:0] cur,
			input logic [3:0] amount, input logic left);
		int nxt;
		nxt = left ? int'(cur) - int'(amount) : int'(cur) + int'(amount);
		if (nxt > COUNT_MAX)
			nxt = COUNT_MAX;
		if (nxt < COUNT_MIN)
			nxt = COUNT_MIN;
		return 16'(nxt);
	endfunction

	// six characters: sign, thousands, hundreds, point, tens, units
	function automatic void queue_readout(input logic signed [15:0] cur);
		int      mag;
		int      shown;
		result_t ch;
		mag = (cur < 0) ? -int'(cur) : int'(cur);
		shown = mag % 10000;
		ch.last_char = 1'b0;
		ch.char_code = (cur < 0) ? ASCII_MINUS : ASCII_PLUS;
		readout_q.push_back(ch);
		ch.char_code = ASCII_ZERO + 8'(shown / 1000);
		readout_q.push_back(ch);
		ch.char_code = ASCII_ZERO + 8'((shown / 100) % 10);
		readout_q.push_back(ch);
		ch.char_code = ASCII_POINT;
		readout_q.push_back(ch);
		ch.char_code = ASCII_ZERO + 8'((shown / 10) % 10);
		readout_q.push_back(ch);
		ch.char_code = ASCII_ZERO + 8'(shown % 10);
		ch.last_char = 1'b1;
		readout_q.push_back(ch);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		result_t want;
		if (!arst_n) begin
			position = '0;
			step = STEP_RESET;
			readout_q.delete();
			errors = 0;
		end else begin
			// compare before queueing, a new report cannot answer in the same cycle
			if (result.valid && result.ready) begin
				if (readout_q.size() == 0) begin
					$display("%0t: unexpected character: expected none, got code %h last %b",
						$time, result.data.char_code, result.data.last_char);
					errors++;
				end else begin
					want = readout_q.pop_front();
					if (result.data.char_code !== want.char_code) begin
						$display("%0t: char_code mismatch: expected %h, got %h",
							$time, want.char_code, result.data.char_code);
						errors++;
					end
					if (result.data.last_char !== want.last_char) begin
						$display("%0t: last_char mismatch: expected %b, got %b",
							$time, want.last_char, result.data.last_char);
						errors++;
					end
				end
			end
			if (item.valid && item.ready) begin
				if (item.data.req_type == REQ_REPORT)
					queue_readout(position);
				else
					position = moved_position(position, step, item.data.moving_left);
			end
			if (psel && penable && pready && paddr[REG_IDX_BIT] == REG_STEP) begin
				if (!pwrite && prdata !== {28'd0, step}) begin
					$display("%0t: step_size read mismatch: expected %h, got %h",
						$time, {28'd0, step}, prdata);
					errors++;
				end
				if (pwrite)
					step = pwdata[3:0];
			end
		end
		fail_count <= errors;
		chars_pending <= readout_q.size();
	end

endmodule

// ===== verif/tb_top.sv =====
// tb_top: clock, reset and stimulus for position_count_bcd_readout, with a checker beside it
// directed requests, short sweeps and random phases over several step sizes
// depends on pcbr_pkg, pcbr_if, pcbr_tb_pkg, pcbr_checker and position_count_bcd_readout

module tb_top;
	import pcbr_pkg::*;
	import pcbr_tb_pkg::*;

	localparam logic [PADDR_W-1:0] STEP_ADDR  = PADDR_W'(REG_STEP) << REG_IDX_BIT;
	localparam logic [PADDR_W-1:0] SPARE_ADDR = PADDR_W'(1) << REG_IDX_BIT;
	localparam int CYCLE_LIMIT = 1000000;

	logic               clk = 1'b0;
	logic               arst_n;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [31:0]        pwdata;
	logic [31:0]        prdata;
	logic               pready;
	int                 fail_count;
	int                 chars_pending;
	int                 cycle_count = 0;
	bit                 burst_mode = 1'b0;

	pcbr_item_if   item_ch ();
	pcbr_result_if result_ch ();

	position_count_bcd_readout u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.item    (item_ch),
		.result  (result_ch)
	);

	pcbr_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready),
		.item          (item_ch),
		.result        (result_ch),
		.fail_count    (fail_count),
		.chars_pending (chars_pending)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// mostly none or short, now and then long
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (burst_mode || r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(4, 20);
	endfunction

	task automatic send_request(input logic kind, input logic left);
		int gap;
		gap = pick_gap();
		if (gap != 0) begin
			item_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_ch.valid <= 1'b1;
		item_ch.data.req_type <= kind;
		item_ch.data.moving_left <= left;
		do @(posedge clk); while (!item_ch.ready);
	endtask

	task automatic write_reg(input logic [PADDR_W-1:0] addr, input logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic read_reg(input logic [PADDR_W-1:0] addr);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= addr;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	// drain every readout, then let a trailing edge request land in the count
	task automatic settle();
		item_ch.valid <= 1'b0;
		do @(posedge clk); while (chars_pending != 0);
		repeat (6) @(posedge clk);
	endtask

	task automatic sweep(input int edges, input logic left, input int report_every);
		for (int n = 1; n <= edges; n++) begin
			send_request(REQ_EDGE, left);
			if (n % report_every == 0)
				send_request(REQ_REPORT, 1'b0);
		end
		send_request(REQ_REPORT, left);
	endtask

	initial begin
		int run;
		int stall;
		result_ch.ready <= 1'b0;
		@(posedge clk);
		forever begin
			run = $urandom_range(1, 24);
			stall = pick_gap();
			result_ch.ready <= 1'b1;
			repeat (run) @(posedge clk);
			if (stall != 0) begin
				result_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
		end
	end

	initial begin
		logic [3:0] phase_step[6];
		int         bias;
		phase_step = '{4'd1, 4'd15, 4'd8, 4'd7, 4'($urandom_range(1, 15)), 4'd5};
		arst_n <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		item_ch.valid <= 1'b0;
		item_ch.data <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset step of two, crossing zero both ways
		read_reg(STEP_ADDR);
		send_request(REQ_REPORT, DIR_RIGHT);
		send_request(REQ_EDGE, DIR_LEFT);
		send_request(REQ_REPORT, DIR_LEFT);
		send_request(REQ_EDGE, DIR_RIGHT);
		send_request(REQ_EDGE, DIR_RIGHT);
		send_request(REQ_REPORT, DIR_RIGHT);
		send_request(REQ_EDGE, DIR_RIGHT);
		settle();

		// zero step holds the count; the spare address changes nothing
		write_reg(STEP_ADDR, 32'd0);
		read_reg(STEP_ADDR);
		send_request(REQ_EDGE, DIR_LEFT);
		send_request(REQ_EDGE, DIR_RIGHT);
		send_request(REQ_REPORT, DIR_LEFT);
		settle();
		write_reg(SPARE_ADDR, 32'hFFFF_FFFF);
		read_reg(STEP_ADDR);
		send_request(REQ_EDGE, DIR_RIGHT);
		send_request(REQ_REPORT, DIR_RIGHT);
		settle();

		// largest step up, then back down through zero, with reports along the way
		write_reg(STEP_ADDR, 32'd15);
		read_reg(STEP_ADDR);
		sweep(8, DIR_RIGHT, 4);
		sweep(16, DIR_LEFT, 4);
		settle();

		for (int ph = 0; ph < 6; ph++) begin
			write_reg(STEP_ADDR, {28'd0, phase_step[ph]});
			read_reg(STEP_ADDR);
			bias = $urandom_range(10, 90);
			burst_mode = (ph == 2);
			for (int k = 0; k < 22; k++) begin
				if ($urandom_range(0, 3) == 0)
					send_request(REQ_REPORT, 1'($urandom_range(0, 1)));
				else
					send_request(REQ_EDGE, $urandom_range(0, 99) < bias);
			end
			settle();
			burst_mode = 1'b0;
		end

		repeat (20) @(posedge clk);
		if (fail_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
